### hw/rtl/b57_pkg.sv
// Shared types, constants and lookup functions for the base57 block codec.
// Depends on nothing; every RTL file of the codec refers to it by scoped names.
`timescale 1ns / 1ps

package b57_pkg;

	localparam int RADIX     = 57;
	localparam int GROUP_LEN = 11;
	localparam int POS_W     = 4;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int WORD_W    = 64;
	// 57^11 exceeds 2^64, so the scaled remainder needs one extra bit.
	localparam int REM_W     = WORD_W + 1;
	localparam int WIDE_W    = 72;

	localparam int IN_TDATA_W    = 72;
	localparam int OUT_FIELDS_W  = CHAR_W + POS_W + WORD_W + 1;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_LEN - 1);

	// First symbol sits in the top byte.
	localparam logic [CHAR_W*RADIX-1:0] ALPHABET =
		"0123456789ACEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	typedef logic [REM_W-1:0]   rem_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [RADIX-1:0][REM_W-1:0] mult_tbl_t;

	typedef struct packed {
		char_t              char_out;
		logic [POS_W-1:0]   digit_position;
		logic               last;
		logic [WORD_W-1:0]  word_out;
		logic               word_valid;
	} result_t;

	typedef struct packed {
		logic   ok;
		digit_t digit;
	} lookup_t;

	function automatic logic [WIDE_W-1:0] pow57(input int n);
		logic [WIDE_W-1:0] p;
		p = WIDE_W'(1);
		for (int i = 0; i < n; i++) begin
			p = p * WIDE_W'(RADIX);
		end
		return p;
	endfunction

	// Entry m holds m*scale, kept to the remainder width.
	function automatic mult_tbl_t build_mults(input logic [WIDE_W-1:0] scale);
		mult_tbl_t         t;
		logic [WIDE_W-1:0] acc;
		acc = '0;
		for (int m = 0; m < RADIX; m++) begin
			t[m] = acc[REM_W-1:0];
			acc  = acc + scale;
		end
		return t;
	endfunction

	localparam logic [WIDE_W-1:0] TOP_POW = pow57(GROUP_LEN - 1);
	localparam rem_t REM_LIMIT = REM_W'(pow57(GROUP_LEN));

	// Thresholds for picking the leading digit, and the same multiples scaled by 57
	// (modulo 2^65) for the remainder update.
	localparam mult_tbl_t DIGIT_STEP = build_mults(TOP_POW);
	localparam mult_tbl_t SHIFT_STEP = build_mults(TOP_POW * WIDE_W'(RADIX));

	function automatic char_t char_of(input digit_t d);
		return ALPHABET[CHAR_W*(RADIX-1-int'(d)) +: CHAR_W];
	endfunction

	function automatic lookup_t digit_of(input char_t ch);
		lookup_t r;
		r = '0;
		for (int k = 0; k < RADIX; k++) begin
			if (ch == ALPHABET[CHAR_W*(RADIX-1-k) +: CHAR_W]) begin
				r.ok    = 1'b1;
				r.digit = DIGIT_W'(k);
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/base57_block_codec.sv
// Top level of the base57 block codec: stream ports, direction register, output register.
// Depends on b57_pkg, b57_enc and b57_dec.
`timescale 1ns / 1ps

//  Channel   Handshake                       Payload
//  cfg       cfg_valid / cfg_ready           cfg_data: direction (0 encode, 1 decode)
//  s_axis    s_axis_tvalid / s_axis_tready   tdata: block_value, text_char
//  m_axis    m_axis_tvalid / m_axis_tready   tdata: char_out, digit_position, word_out,
//                                            word_valid; tlast: last
//
// Encode: a word is taken in one handshake and its eleven characters leave one per cycle
// while m_axis does not stall; the one-character-per-cycle result channel sets that pace.
// The next word is taken in the cycle the last character of the current one goes into the
// output register.
// Decode: one character per cycle while m_axis does not stall; the eleventh character's
// item yields the word in the output register in the next cycle.
// Reset (arst_n low) selects encode, empties the engine and the output register and
// clears the decode state. A stalled m_axis holds the output register and, through
// it, both engines; writing the direction register drops any partial decode group.

module base57_block_codec (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data,

	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [63:0] block_value, [71:64] text_char
	input  logic [b57_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] char_out, [11:8] digit_position, [75:12] word_out, [76] word_valid,
	// [79:77] zero
	output logic [b57_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast
);

	localparam int OUT_PAD = b57_pkg::OUT_TDATA_W - b57_pkg::OUT_FIELDS_W;

	logic                        direction_q;
	logic                        out_valid_q;
	b57_pkg::result_t            res_q;

	logic                        out_open;
	logic                        take;
	logic                        enc_can_load;
	logic                        enc_fire;
	logic                        dec_fire;
	b57_pkg::result_t            enc_res;
	b57_pkg::result_t            dec_res;
	logic                        res_fire;
	b57_pkg::result_t            res;

	// The direction register is always writable; the user writes it only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_valid) begin
			direction_q <= cfg_data;
		end
	end

	// The output register takes a new result whenever it is empty or being drained.
	assign out_open      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = direction_q ? out_open : enc_can_load;
	assign take          = s_axis_tvalid && s_axis_tready;

	b57_enc u_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take && !direction_q),
		.load_value (s_axis_tdata[b57_pkg::WORD_W-1:0]),
		.adv        (out_open),
		.can_load   (enc_can_load),
		.fire       (enc_fire),
		.res        (enc_res)
	);

	b57_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_valid),
		.take      (take && direction_q),
		.text_char (s_axis_tdata[b57_pkg::WORD_W +: b57_pkg::CHAR_W]),
		.fire      (dec_fire),
		.res       (dec_res)
	);

	// Only the selected engine fires if the user switches direction while idle.
	assign res_fire = enc_fire || dec_fire;
	assign res      = direction_q ? dec_res : enc_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_open && res_fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, res_q.word_valid, res_q.word_out,
		res_q.digit_position, res_q.char_out};

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(enc_fire && dec_fire))
		else $error("both engines produced a result in one cycle");

endmodule

### hw/rtl/b57_enc.sv
// Encode engine: turns one 64-bit word into eleven base57 characters, leading digit first.
// Depends on b57_pkg for the digit thresholds, the alphabet and the result struct.
`timescale 1ns / 1ps

module b57_enc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [b57_pkg::WORD_W-1:0]    load_value,
	input  logic                          adv,
	output logic                          can_load,
	output logic                          fire,
	output b57_pkg::result_t              res
);

	logic                         busy_q;
	logic [b57_pkg::POS_W-1:0]    pos_q;
	b57_pkg::rem_t                rem_q;
	b57_pkg::digit_t              digit;
	b57_pkg::rem_t                rem_x57;
	b57_pkg::rem_t                rem_next;
	logic                         done;

	// The remainder is kept scaled so that its leading digit is always rem / 57^10.
	always_comb begin
		digit = '0;
		for (int m = 1; m < b57_pkg::RADIX; m++) begin
			if (rem_q >= b57_pkg::DIGIT_STEP[m]) begin
				digit = b57_pkg::DIGIT_W'(m);
			end
		end
	end

	assign rem_x57  = (rem_q << 6) - (rem_q << 3) + rem_q;
	assign rem_next = rem_x57 - b57_pkg::SHIFT_STEP[digit];

	assign fire     = busy_q && adv;
	assign done     = fire && (pos_q == b57_pkg::LAST_POS);
	assign can_load = !busy_q || done;

	always_comb begin
		res                = '0;
		res.char_out       = b57_pkg::char_of(digit);
		res.digit_position = pos_q;
		res.last           = (pos_q == b57_pkg::LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (fire) begin
			pos_q <= pos_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, load_value};
		end else if (fire) begin
			rem_q <= rem_next;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q <= b57_pkg::LAST_POS)
		else $error("encode position ran past the group");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < b57_pkg::REM_LIMIT)
		else $error("encode remainder out of range");

endmodule

### hw/rtl/b57_dec.sv
// Decode accumulator: folds one base57 character per item into a 64-bit word.
// Depends on b57_pkg for the character lookup and the result struct.
`timescale 1ns / 1ps

module b57_dec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  take,
	input  b57_pkg::char_t        text_char,
	output logic                  fire,
	output b57_pkg::result_t      res
);

	logic [b57_pkg::WORD_W-1:0]  acc_q;
	logic [b57_pkg::POS_W-1:0]   cnt_q;
	logic                        bad_q;
	b57_pkg::lookup_t            lk;
	logic [b57_pkg::WORD_W-1:0]  acc_next;
	logic                        bad_next;

	assign lk       = b57_pkg::digit_of(text_char);
	// A character outside the alphabet counts as digit zero and spoils the word.
	assign acc_next = (acc_q << 6) - (acc_q << 3) + acc_q
		+ b57_pkg::WORD_W'(lk.ok ? lk.digit : '0);
	assign bad_next = bad_q || !lk.ok;
	assign fire     = take && (cnt_q == b57_pkg::LAST_POS);

	always_comb begin
		res            = '0;
		res.last       = 1'b1;
		res.word_out   = bad_next ? '0 : acc_next;
		res.word_valid = !bad_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			bad_q <= 1'b0;
		end else if (clear || fire) begin
			acc_q <= '0;
			cnt_q <= '0;
			bad_q <= 1'b0;
		end else if (take) begin
			acc_q <= acc_next;
			cnt_q <= cnt_q + 1'b1;
			bad_q <= bad_next;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= b57_pkg::LAST_POS)
		else $error("decode character count ran past the group");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (cnt_q == '0) && !bad_q && (acc_q == '0))
		else $error("decode state not cleared after a word");

endmodule

### test/base57_block_codec_checker.sv
// Checker for the base57 block codec: watches the configuration, input and result channels,
// predicts every result and compares it field by field. Depends on b57_pkg for result_t and widths.
`timescale 1ns / 1ps

module base57_block_codec_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// [63:0] block_value, [71:64] text_char
	input  logic [b57_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] char_out, [11:8] digit_position, [75:12] word_out, [76] word_valid, [79:77] zero
	input  logic [b57_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast,
	output int                              mismatches,
	output int                              awaited,
	output int                              words_encoded,
	output int                              groups_decoded,
	output int                              groups_rejected
);

	localparam int NUM_SYMBOLS = 57;
	localparam int GROUP_CHARS = 11;
	localparam logic [8*NUM_SYMBOLS-1:0] SYMBOLS =
		"0123456789ACEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
	localparam int REPORT_LIMIT = 10;
	localparam int POS_LSB = 8;
	localparam int WORD_LSB = 12;
	localparam int VALID_BIT = 76;
	localparam int PAD_LSB = 77;

	b57_pkg::result_t expected_q [$];
	logic             decode_mode;
	logic [63:0]      partial_word;
	logic [3:0]       chars_taken;
	logic             group_bad;
	b57_pkg::result_t want;

	function automatic logic [7:0] symbol_at(input int k);
		return SYMBOLS[8*(NUM_SYMBOLS-1-k) +: 8];
	endfunction

	// Digit value of a character, or NUM_SYMBOLS when it is not a base57 symbol.
	function automatic int digit_value(input logic [7:0] ch);
		int v;
		v = NUM_SYMBOLS;
		for (int k = 0; k < NUM_SYMBOLS; k++) begin
			if (symbol_at(k) == ch) begin
				v = k;
			end
		end
		return v;
	endfunction

	task automatic queue_encoding(input logic [63:0] word);
		logic [63:0]      rest;
		logic [5:0]       digs [GROUP_CHARS];
		b57_pkg::result_t r;
		rest = word;
		for (int j = GROUP_CHARS - 1; j >= 0; j--) begin
			digs[j] = 6'(rest % 64'd57);
			rest = rest / 64'd57;
		end
		for (int k = 0; k < GROUP_CHARS; k++) begin
			r = '0;
			r.char_out = symbol_at(int'(digs[k]));
			r.digit_position = 4'(k);
			r.last = (k == GROUP_CHARS - 1);
			expected_q.push_back(r);
		end
		words_encoded++;
	endtask

	task automatic absorb_char(input logic [7:0] ch);
		int               d;
		b57_pkg::result_t r;
		d = digit_value(ch);
		if (d >= NUM_SYMBOLS) begin
			group_bad = 1'b1;
			d = 0;
		end
		partial_word = partial_word * 64'd57 + 64'(d);
		chars_taken = chars_taken + 4'd1;
		if (chars_taken == 4'(GROUP_CHARS)) begin
			r = '0;
			r.last = 1'b1;
			r.word_out = group_bad ? 64'd0 : partial_word;
			r.word_valid = !group_bad;
			expected_q.push_back(r);
			groups_decoded++;
			if (group_bad) begin
				groups_rejected++;
			end
			partial_word = '0;
			chars_taken = '0;
			group_bad = 1'b0;
		end
	endtask

	task automatic note(input string what, input logic [63:0] exp_val, input logic [63:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t mismatch in %s: expected %h, got %h", $time, what, exp_val, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode = 1'b0;
			partial_word = '0;
			chars_taken = '0;
			group_bad = 1'b0;
			expected_q.delete();
		end else begin
			// Results first, so a stray result is never paired with an item taken at this edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					note("result with nothing expected", 64'd0, m_axis_tdata[63:0]);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tdata[7:0] !== want.char_out)
						note("char_out", 64'(want.char_out), 64'(m_axis_tdata[7:0]));
					if (m_axis_tdata[POS_LSB +: 4] !== want.digit_position)
						note("digit_position", 64'(want.digit_position),
							64'(m_axis_tdata[POS_LSB +: 4]));
					if (m_axis_tlast !== want.last)
						note("last", 64'(want.last), 64'(m_axis_tlast));
					if (m_axis_tdata[WORD_LSB +: 64] !== want.word_out)
						note("word_out", want.word_out, m_axis_tdata[WORD_LSB +: 64]);
					if (m_axis_tdata[VALID_BIT] !== want.word_valid)
						note("word_valid", 64'(want.word_valid), 64'(m_axis_tdata[VALID_BIT]));
					if (m_axis_tdata[b57_pkg::OUT_TDATA_W-1:PAD_LSB] !== '0)
						note("tdata padding", 64'd0,
							64'(m_axis_tdata[b57_pkg::OUT_TDATA_W-1:PAD_LSB]));
				end
			end
			// A direction write also drops any partial decode group.
			if (cfg_valid && cfg_ready) begin
				decode_mode = cfg_data;
				partial_word = '0;
				chars_taken = '0;
				group_bad = 1'b0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_mode) begin
					absorb_char(s_axis_tdata[71:64]);
				end else begin
					queue_encoding(s_axis_tdata[63:0]);
				end
			end
		end
		awaited = expected_q.size();
	end

endmodule

### test/base57_block_codec_test.sv
// Testbench top for the base57 block codec: clock, reset, stimulus on all three channels and verdict.
// Depends on b57_pkg, base57_block_codec and base57_block_codec_checker.
`timescale 1ns / 1ps

module base57_block_codec_test;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;
	// Cycles allowed after the last expected result before the codec counts as idle; covers
	// characters of a partial group that cause no result but may still be in flight.
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_NS = 3_000_000;
	localparam int NUM_SYMBOLS = 57;

	// Kinds of random decode groups.
	localparam int GROUP_CLEAN = 0;
	localparam int GROUP_DIRTY = 1;
	localparam int GROUP_ONE_BAD = 2;
	localparam int GROUP_PARTIAL = 3;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic                            cfg_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// [63:0] block_value, [71:64] text_char
	logic [b57_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// [7:0] char_out, [11:8] digit_position, [75:12] word_out, [76] word_valid, [79:77] zero
	logic [b57_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;

	int   mismatches;
	int   awaited;
	int   words_encoded;
	int   groups_decoded;
	int   groups_rejected;
	int   dir_writes;
	int   item_no;
	int   stall_left;
	int   fails;
	logic bursts_on;
	logic quiet;

	base57_block_codec u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	base57_block_codec_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.mismatches      (mismatches),
		.awaited         (awaited),
		.words_encoded   (words_encoded),
		.groups_decoded  (groups_decoded),
		.groups_rejected (groups_rejected)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The run is bounded by simulation time in case a handshake never completes.
	initial begin
		#(WATCHDOG_NS);
		$display("Timed out with %0d results still awaited.", awaited);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: ready drops in bursts at random while bursts are enabled.
	initial begin
		m_axis_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Writes the direction register; the codec must be idle when this is called.
	task automatic set_direction(input logic dir);
		cfg_data <= dir;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		dir_writes++;
	endtask

	// Offers one item and returns at the falling edge after it was taken. Only the field that
	// the current direction reads matters, but both are always filled so every bit toggles.
	task automatic push_item(input logic [63:0] blk, input logic [7:0] ch);
		item_no++;
		// Idling switches on and off in stretches of 32 items.
		if (item_no % 32 == 0) begin
			bursts_on = !quiet && ($urandom_range(0, 3) != 0);
		end
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tdata <= {ch, blk};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted result has been accepted.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly full-range words, with small values, near-maximum values and powers of 57 mixed in.
	function automatic logic [63:0] random_word();
		logic [63:0] p;
		int          n;
		p = 64'd1;
		n = $urandom_range(1, 10);
		case ($urandom_range(0, 7))
			0: return 64'($urandom_range(0, 300));
			1: return ~64'($urandom_range(0, 300));
			2: begin
				for (int i = 0; i < n; i++) begin
					p = p * 64'd57;
				end
				return p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [7:0] pick_symbol();
		return b57_pkg::ALPHABET[8*(NUM_SYMBOLS - 1 - int'($urandom_range(0, NUM_SYMBOLS - 1))) +: 8];
	endfunction

	// Bytes just outside the alphabet, plus the byte extremes, for the single-bad-character groups.
	function automatic logic [7:0] pick_stranger();
		case ($urandom_range(0, 7))
			0: return "B";
			1: return "D";
			2: return "I";
			3: return "O";
			4: return "l";
			5: return 8'h00;
			6: return 8'hFF;
			default: return "{";
		endcase
	endfunction

	// One decode group of random content. A partial group is cut short and then dropped by
	// rewriting the direction register.
	task automatic send_group(input int kind);
		int len;
		int bad_at;
		len = (kind == GROUP_PARTIAL) ? $urandom_range(1, 10) : 11;
		bad_at = $urandom_range(0, 10);
		for (int i = 0; i < len; i++) begin
			case (kind)
				GROUP_DIRTY: push_item({$urandom, $urandom},
					($urandom_range(0, 1) == 0) ? pick_symbol() : 8'($urandom));
				GROUP_ONE_BAD: push_item({$urandom, $urandom},
					(i == bad_at) ? pick_stranger() : pick_symbol());
				default: push_item({$urandom, $urandom}, pick_symbol());
			endcase
		end
		if (kind == GROUP_PARTIAL) begin
			settle();
			set_direction(DIR_DECODE);
		end
	endtask

	task automatic random_decode(input int groups);
		int r;
		for (int g = 0; g < groups; g++) begin
			r = $urandom_range(0, 9);
			if (r < 6) send_group(GROUP_CLEAN);
			else if (r < 8) send_group(GROUP_DIRTY);
			else if (r < 9) send_group(GROUP_ONE_BAD);
			else send_group(GROUP_PARTIAL);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = DIR_ENCODE;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		bursts_on = 1'b0;
		quiet = 1'b0;
		item_no = 0;
		dir_writes = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed encode: zero, the smallest and largest single digit, the boundary between
		// ten and eleven significant digits, the top bit alone and the all-ones word.
		set_direction(DIR_ENCODE);
		push_item(64'd0, 8'h00);
		push_item(64'd1, 8'hFF);
		push_item(64'd56, "z");
		push_item(64'd362033331456891248, "0");
		push_item(64'd362033331456891249, "A");
		push_item(64'h8000_0000_0000_0000, 8'h80);
		push_item(64'hFFFF_FFFF_FFFF_FFFF, 8'h7F);
		settle();

		// Directed decode: a partial group holding characters outside the alphabet is dropped
		// by a direction write, so the all-'z' group after it must decode as valid and wrap.
		set_direction(DIR_DECODE);
		push_item(64'hFFFF_FFFF_FFFF_FFFF, "7");
		push_item(64'd0, "B");
		push_item(64'd0, 8'hFF);
		settle();
		set_direction(DIR_DECODE);
		for (int i = 0; i < 11; i++) begin
			push_item({$urandom, $urandom}, "z");
		end
		settle();

		// Random encode, with one full drain in the middle of the stream.
		bursts_on = 1'b1;
		set_direction(DIR_ENCODE);
		for (int i = 0; i < 90; i++) begin
			if (i == 45) settle();
			push_item(random_word(), 8'($urandom));
		end
		settle();

		set_direction(DIR_DECODE);
		random_decode(12);
		settle();

		set_direction(DIR_ENCODE);
		for (int i = 0; i < 60; i++) begin
			push_item(random_word(), 8'($urandom));
		end
		settle();

		// Last part: both channels run without idling.
		quiet = 1'b1;
		bursts_on = 1'b0;
		set_direction(DIR_DECODE);
		random_decode(8);
		settle();
		set_direction(DIR_ENCODE);
		for (int i = 0; i < 15; i++) begin
			push_item(random_word(), 8'($urandom));
		end
		settle();

		fails = mismatches + awaited;
		$display("Encoded %0d words and decoded %0d groups, %0d of them with stray characters,",
			words_encoded, groups_decoded, groups_rejected);
		$display("over %0d direction writes with random idling on both channels; %0d mismatches.",
			dir_writes, mismatches);
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/b57_pkg.sv
hw/rtl/b57_enc.sv
hw/rtl/b57_dec.sv
hw/rtl/base57_block_codec.sv
test/base57_block_codec_checker.sv
test/base57_block_codec_test.sv
